// ----- sv/priority_drop_byte_budget_queue_macros.svh -----
// Assertion macros for the priority drop byte budget queue checker.
// Used by pdbq_checker.sv; no other dependencies.
`ifndef PRIORITY_DROP_BYTE_BUDGET_QUEUE_MACROS_SVH
`define PRIORITY_DROP_BYTE_BUDGET_QUEUE_MACROS_SVH

// same-cycle implication, off during reset
`define PDBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PDBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define PDBQ_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pdbq_pkg.sv -----
// Shared types and constants for the priority drop byte budget queue.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pdbq_pkg;

  localparam int unsigned BYTES_W = 24;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned CTR_W = 32;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] REQ_PUBLISH = 2'd0;
  localparam logic [1:0] REQ_FLUSH   = 2'd1;
  localparam logic [1:0] REQ_DISCARD = 2'd2;

  localparam logic [1:0] PRIO_LOW    = 2'd0;
  localparam logic [1:0] PRIO_MEDIUM = 2'd1;
  localparam logic [1:0] PRIO_HIGH   = 2'd2;
  localparam logic [1:0] PRIO_ALIAS  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_LIMIT     = 2'd2;

  localparam logic [CFG_W-1:0] MIN_BUDGET       = CFG_W'(32 * 1024);
  localparam logic [CFG_W-1:0] MIN_BACKPRESSURE = CFG_W'(8 * 1024);

  // search token travelling along the cell row
  typedef struct packed {
    logic active;
    logic hit;
  } wave_t;

  // per-cell controls from the queue controller
  typedef struct packed {
    logic       load;
    logic       trim;
    logic       occupied;
    logic [1:0] match_prio;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/pdbq_if.sv -----
// Channel interfaces: request channel and result channel, valid/ready.
// Depends on pdbq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pdbq_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [pdbq_pkg::BYTES_W-1:0] pkt_size;
  logic [1:0]                   priority_req;
  logic                         droppable;
  logic [pdbq_pkg::BYTES_W-1:0] sink_pending;
  logic [pdbq_pkg::BYTES_W-1:0] sink_accepted;
  logic                         write_failed;

  modport source (
    output valid, req_type, pkt_size, priority_req, droppable,
           sink_pending, sink_accepted, write_failed,
    input  ready
  );
  modport sink (
    input  valid, req_type, pkt_size, priority_req, droppable,
           sink_pending, sink_accepted, write_failed,
    output ready
  );
endinterface

interface pdbq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [pdbq_pkg::CNT_OUT_W-1:0] evicted_count;
  logic [pdbq_pkg::BYTES_W-1:0]   sent_bytes;
  logic                           packet_done;
  logic [pdbq_pkg::BYTES_W-1:0]   queued_bytes_now;
  logic [pdbq_pkg::CNT_OUT_W-1:0] queued_count_now;
  logic [pdbq_pkg::CTR_W-1:0]     drops_low_total;
  logic [pdbq_pkg::CTR_W-1:0]     drops_medium_total;
  logic [pdbq_pkg::CTR_W-1:0]     drops_high_total;
  logic [pdbq_pkg::CTR_W-1:0]     sent_total;
  logic [pdbq_pkg::CTR_W-1:0]     write_errors_total;

  modport source (
    output valid, accepted, evicted_count, sent_bytes, packet_done,
           queued_bytes_now, queued_count_now, drops_low_total,
           drops_medium_total, drops_high_total, sent_total, write_errors_total,
    input  ready
  );
  modport sink (
    input  valid, accepted, evicted_count, sent_bytes, packet_done,
           queued_bytes_now, queued_count_now, drops_low_total,
           drops_medium_total, drops_high_total, sent_total, write_errors_total,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/pdbq_cell.sv -----
// One queue slot of the cell row: descriptor registers and search token stage.
// Depends on pdbq_pkg for wave_t and cell_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pdbq_cell #(
  parameter int unsigned SW = 24
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire pdbq_pkg::cell_cmd_t cmd,
  input  wire  [SW-1:0]            wr_size,
  input  wire  [1:0]               wr_prio,
  input  wire                      wr_drop,
  input  wire  [SW-1:0]            trim_size,
  input  wire pdbq_pkg::wave_t     wave_in,
  input  wire  [SW-1:0]            wave_size_in,
  input  wire  [SW-1:0]            nb_size,
  input  wire  [1:0]               nb_prio,
  input  wire                      nb_drop,
  output logic [SW-1:0]            size_q,
  output logic [1:0]               prio_q,
  output logic                     drop_q,
  output pdbq_pkg::wave_t          wave_out,
  output logic [SW-1:0]            wave_size_out
);

  logic [SW-1:0]   size_r, size_nxt;
  logic [1:0]      prio_r, prio_nxt;
  logic            drop_r, drop_nxt;
  pdbq_pkg::wave_t wave_r;
  logic [SW-1:0]   wave_size_r;
  logic            hit_here;
  logic            shift;

  assign hit_here = wave_r.active & ~wave_r.hit & cmd.occupied & drop_r &
                    (prio_r == cmd.match_prio);
  assign shift    = wave_r.active & (wave_r.hit | hit_here);

  assign wave_out.active = wave_r.active;
  assign wave_out.hit    = wave_r.hit | hit_here;
  assign wave_size_out   = hit_here ? size_r : wave_size_r;

  assign size_q = size_r;
  assign prio_q = prio_r;
  assign drop_q = drop_r;

  always_comb begin
    size_nxt = size_r;
    prio_nxt = prio_r;
    drop_nxt = drop_r;
    if (cmd.load) begin
      size_nxt = wr_size;
      prio_nxt = wr_prio;
      drop_nxt = wr_drop;
    end else if (cmd.trim) begin
      size_nxt = trim_size;
    end else if (shift) begin
      // close the gap: take the younger neighbour
      size_nxt = nb_size;
      prio_nxt = nb_prio;
      drop_nxt = nb_drop;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    prio_r      <= prio_nxt;
    drop_r      <= drop_nxt;
    wave_size_r <= wave_size_in;
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/priority_drop_byte_budget_queue.sv -----
// Priority tail-drop packet descriptor queue under a byte budget: controller
// and a row of pdbq_cell slots. Depends on pdbq_pkg, pdbq_if and pdbq_cell.
//
//   channel   | dir | transfer         | payload
//   in_chan   | in  | valid & ready    | request: type, packet, sink status
//   out_chan  | out | valid & ready    | one result per request, counters
//   cfg_*     | in  | cfg_we           | enable, byte budget, bp limit
//
// Flush, discard, no-op and publishes settled at once go from S_EVAL straight
// to S_FIN. A publish that reaches the budget check passes S_EVAL, S_CHECK and
// S_FIN; each eviction search adds up to priority+1 token passes down the cell
// row and a return to S_CHECK after a hit. Popping the head after a flush
// adds one pass. A stalled result holds only the completion of the following
// request. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module priority_drop_byte_budget_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned SIZE_WIDTH  = 24
) (
  input  wire                                clk,
  input  wire                                rst_n,
  pdbq_in_if.sink                            in_chan,
  pdbq_out_if.source                         out_chan,
  input  wire                                cfg_we,
  input  wire  [pdbq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [pdbq_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned SW   = SIZE_WIDTH;
  localparam int unsigned XW   = (SW > pdbq_pkg::BYTES_W) ? SW : pdbq_pkg::BYTES_W;
  localparam int unsigned TW   = XW + 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BW   = pdbq_pkg::BYTES_W;
  localparam int unsigned CW   = pdbq_pkg::CTR_W;
  localparam int unsigned OW   = pdbq_pkg::CNT_OUT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // configuration
  logic                        enable_r;
  logic [pdbq_pkg::CFG_W-1:0]  budget_r;
  logic [pdbq_pkg::CFG_W-1:0]  bpl_r;
  logic [pdbq_pkg::CFG_W-1:0]  budget_eff;
  logic [pdbq_pkg::CFG_W-1:0]  bpl_eff;

  // captured request
  logic [1:0]    req_r;
  logic [SW-1:0] bytes_r;
  logic [1:0]    prio_r;
  logic          drop_r;
  logic [BW-1:0] pend_r;
  logic [BW-1:0] acc_r;
  logic          fail_r;

  // control and queue state
  logic [2:0]      state_r, state_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [TW-1:0]   total_r, total_nxt;
  logic [CW-1:0]   low_r, low_nxt, med_r, med_nxt, high_r, high_nxt;
  logic [CW-1:0]   sentpk_r, sentpk_nxt, wrerr_r, wrerr_nxt;
  logic [1:0]      sweep_prio_r, sweep_prio_nxt;

  // result of the request in progress
  logic            res_acc_r, res_acc_nxt;
  logic [CNTW-1:0] res_evict_r, res_evict_nxt;
  logic [XW-1:0]   res_sent_r, res_sent_nxt;
  logic            res_done_r, res_done_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  logic            out_acc_r;
  logic [OW-1:0]   out_evict_r;
  logic [BW-1:0]   out_sent_r;
  logic            out_done_r;
  logic [BW-1:0]   out_qbytes_r;
  logic [OW-1:0]   out_qcount_r;
  logic [CW-1:0]   out_low_r, out_med_r, out_high_r, out_sentpk_r, out_wrerr_r;

  logic            slot_free;
  logic            in_ready;
  logic            take;
  logic            emit;
  logic            wr_en;
  logic            trim_en;
  logic            drop_inc;
  logic [1:0]      drop_prio;
  pdbq_pkg::wave_t inject;
  logic [SW-1:0]   head;
  logic [SW-1:0]   trim_size;
  logic [TW:0]     sum;
  logic            fits;
  logic            oversize;
  logic            acc_ge_head;

  // cell row
  pdbq_pkg::cell_cmd_t cmd      [QUEUE_DEPTH];
  logic [SW-1:0]       size_q   [QUEUE_DEPTH];
  logic [1:0]          cprio_q  [QUEUE_DEPTH];
  logic                cdrop_q  [QUEUE_DEPTH];
  pdbq_pkg::wave_t     wave_o   [QUEUE_DEPTH];
  logic [SW-1:0]       wsize_o  [QUEUE_DEPTH];

  assign budget_eff = (budget_r < pdbq_pkg::MIN_BUDGET) ? pdbq_pkg::MIN_BUDGET : budget_r;
  assign bpl_eff    = (bpl_r < pdbq_pkg::MIN_BACKPRESSURE) ? pdbq_pkg::MIN_BACKPRESSURE
                                                            : bpl_r;

  assign head        = size_q[0];
  assign trim_size   = head - SW'(acc_r);
  assign sum         = {1'b0, total_r} + (TW + 1)'(bytes_r);
  assign fits        = sum <= (TW + 1)'(budget_eff);
  assign oversize    = XW'(bytes_r) > XW'(budget_eff);
  assign acc_ge_head = XW'(acc_r) >= XW'(head);

  assign slot_free = ~out_valid_r | out_chan.ready;
  assign in_ready  = (state_r == S_IDLE) | ((state_r == S_FIN) & slot_free);
  assign take      = in_chan.valid & in_ready;
  assign in_chan.ready = in_ready;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      pdbq_pkg::wave_t w_in;
      logic [SW-1:0]   ws_in;
      logic [SW-1:0]   nb_size;
      logic [1:0]      nb_prio;
      logic            nb_drop;

      assign cmd[gi].load       = wr_en & (count_r == CNTW'(gi));
      assign cmd[gi].trim       = trim_en & (gi == 0);
      assign cmd[gi].occupied   = CNTW'(gi) < count_r;
      assign cmd[gi].match_prio = sweep_prio_r;

      if (gi == 0) begin : g_first
        assign w_in  = inject;
        assign ws_in = '0;
      end else begin : g_next
        assign w_in  = wave_o[gi-1];
        assign ws_in = wsize_o[gi-1];
      end

      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign nb_size = size_q[gi];
        assign nb_prio = cprio_q[gi];
        assign nb_drop = cdrop_q[gi];
      end else begin : g_mid
        assign nb_size = size_q[gi+1];
        assign nb_prio = cprio_q[gi+1];
        assign nb_drop = cdrop_q[gi+1];
      end

      pdbq_cell #(.SW(SW)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd[gi]),
        .wr_size      (bytes_r),
        .wr_prio      (prio_r),
        .wr_drop      (drop_r),
        .trim_size    (trim_size),
        .wave_in      (w_in),
        .wave_size_in (ws_in),
        .nb_size      (nb_size),
        .nb_prio      (nb_prio),
        .nb_drop      (nb_drop),
        .size_q       (size_q[gi]),
        .prio_q       (cprio_q[gi]),
        .drop_q       (cdrop_q[gi]),
        .wave_out     (wave_o[gi]),
        .wave_size_out(wsize_o[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    sentpk_nxt     = sentpk_r;
    wrerr_nxt      = wrerr_r;
    sweep_prio_nxt = sweep_prio_r;
    res_acc_nxt    = res_acc_r;
    res_evict_nxt  = res_evict_r;
    res_sent_nxt   = res_sent_r;
    res_done_nxt   = res_done_r;
    inject         = '0;
    wr_en          = 1'b0;
    trim_en        = 1'b0;
    drop_inc       = 1'b0;
    drop_prio      = prio_r;
    emit           = 1'b0;

    case (state_r)
      S_IDLE: begin
        state_nxt = S_IDLE;
      end
      S_EVAL: begin
        state_nxt = S_FIN;
        case (req_r)
          pdbq_pkg::REQ_PUBLISH: begin
            if (enable_r) begin
              if ((bytes_r == '0) || (drop_r && oversize)) begin
                drop_inc = 1'b1;
              end else begin
                state_nxt = S_CHECK;
              end
            end
          end
          pdbq_pkg::REQ_FLUSH: begin
            if ((count_r != '0) && (pend_r < bpl_eff)) begin
              if (fail_r) begin
                wrerr_nxt = wrerr_r + CW'(1);
              end else if (acc_r != '0) begin
                if (acc_ge_head) begin
                  total_nxt     = total_r - TW'(head);
                  res_sent_nxt  = XW'(head);
                  res_done_nxt  = 1'b1;
                  sentpk_nxt    = sentpk_r + CW'(1);
                  inject.active = 1'b1;
                  inject.hit    = 1'b1;
                  state_nxt     = S_POP;
                end else begin
                  trim_en      = 1'b1;
                  total_nxt    = total_r - TW'(acc_r);
                  res_sent_nxt = XW'(acc_r);
                end
              end
            end
          end
          pdbq_pkg::REQ_DISCARD: begin
            count_nxt = '0;
            total_nxt = '0;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_CHECK: begin
        if (fits) begin
          state_nxt = S_FIN;
          if (count_r < CNTW'(QUEUE_DEPTH)) begin
            wr_en       = 1'b1;
            count_nxt   = count_r + CNTW'(1);
            total_nxt   = total_r + TW'(bytes_r);
            res_acc_nxt = 1'b1;
          end else begin
            drop_inc = 1'b1;
          end
        end else begin
          sweep_prio_nxt = pdbq_pkg::PRIO_LOW;
          inject.active  = 1'b1;
          state_nxt      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (wave_o[QUEUE_DEPTH-1].active) begin
          if (wave_o[QUEUE_DEPTH-1].hit) begin
            total_nxt     = total_r - TW'(wsize_o[QUEUE_DEPTH-1]);
            count_nxt     = count_r - CNTW'(1);
            drop_inc      = 1'b1;
            drop_prio     = sweep_prio_r;
            res_evict_nxt = res_evict_r + CNTW'(1);
            state_nxt     = S_CHECK;
          end else if (sweep_prio_r < prio_r) begin
            sweep_prio_nxt = sweep_prio_r + 2'd1;
            inject.active  = 1'b1;
          end else begin
            drop_inc  = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_POP: begin
        if (wave_o[QUEUE_DEPTH-1].active) begin
          count_nxt = count_r - CNTW'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (take) begin
      state_nxt     = S_EVAL;
      res_acc_nxt   = 1'b0;
      res_evict_nxt = '0;
      res_sent_nxt  = '0;
      res_done_nxt  = 1'b0;
    end
  end

  always_comb begin
    low_nxt  = low_r;
    med_nxt  = med_r;
    high_nxt = high_r;
    if (drop_inc) begin
      case (drop_prio)
        pdbq_pkg::PRIO_HIGH:   high_nxt = high_r + CW'(1);
        pdbq_pkg::PRIO_MEDIUM: med_nxt  = med_r + CW'(1);
        default:               low_nxt  = low_r + CW'(1);
      endcase
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      low_r        <= '0;
      med_r        <= '0;
      high_r       <= '0;
      sentpk_r     <= '0;
      wrerr_r      <= '0;
      sweep_prio_r <= pdbq_pkg::PRIO_LOW;
      res_acc_r    <= 1'b0;
      res_evict_r  <= '0;
      res_sent_r   <= '0;
      res_done_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      enable_r     <= 1'b0;
      budget_r     <= pdbq_pkg::MIN_BUDGET;
      bpl_r        <= pdbq_pkg::MIN_BACKPRESSURE;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      low_r        <= low_nxt;
      med_r        <= med_nxt;
      high_r       <= high_nxt;
      sentpk_r     <= sentpk_nxt;
      wrerr_r      <= wrerr_nxt;
      sweep_prio_r <= sweep_prio_nxt;
      res_acc_r    <= res_acc_nxt;
      res_evict_r  <= res_evict_nxt;
      res_sent_r   <= res_sent_nxt;
      res_done_r   <= res_done_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pdbq_pkg::CFG_ENABLE:      enable_r <= cfg_wdata[0];
          pdbq_pkg::CFG_BYTE_BUDGET: budget_r <= cfg_wdata;
          pdbq_pkg::CFG_BP_LIMIT:    bpl_r    <= cfg_wdata;
          default: begin
            enable_r <= enable_r;
          end
        endcase
      end
    end
  end

  // capture request and load results; payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      req_r   <= in_chan.req_type;
      bytes_r <= SW'(in_chan.pkt_size);
      prio_r  <= (in_chan.priority_req == pdbq_pkg::PRIO_ALIAS) ? pdbq_pkg::PRIO_LOW
                                                                 : in_chan.priority_req;
      drop_r  <= in_chan.droppable;
      pend_r  <= in_chan.sink_pending;
      acc_r   <= in_chan.sink_accepted;
      fail_r  <= in_chan.write_failed;
    end
    if (emit) begin
      out_acc_r    <= res_acc_r;
      out_evict_r  <= OW'(res_evict_r);
      out_sent_r   <= res_sent_r[BW-1:0];
      out_done_r   <= res_done_r;
      out_qbytes_r <= total_r[BW-1:0];
      out_qcount_r <= OW'(count_r);
      out_low_r    <= low_r;
      out_med_r    <= med_r;
      out_high_r   <= high_r;
      out_sentpk_r <= sentpk_r;
      out_wrerr_r  <= wrerr_r;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.accepted           = out_acc_r;
  assign out_chan.evicted_count      = out_evict_r;
  assign out_chan.sent_bytes         = out_sent_r;
  assign out_chan.packet_done        = out_done_r;
  assign out_chan.queued_bytes_now   = out_qbytes_r;
  assign out_chan.queued_count_now   = out_qcount_r;
  assign out_chan.drops_low_total    = out_low_r;
  assign out_chan.drops_medium_total = out_med_r;
  assign out_chan.drops_high_total   = out_high_r;
  assign out_chan.sent_total         = out_sentpk_r;
  assign out_chan.write_errors_total = out_wrerr_r;

endmodule

`default_nettype wire

// ----- sv/pdbq_checker.sv -----
// Port-level checks of the result channel, bound to the top level.
// Depends on priority_drop_byte_budget_queue_macros.svh and pdbq_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_drop_byte_budget_queue_macros.svh"

module pdbq_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire                           accepted,
  input wire [pdbq_pkg::CNT_OUT_W-1:0] evicted_count,
  input wire [pdbq_pkg::BYTES_W-1:0]   sent_bytes,
  input wire                           packet_done,
  input wire [pdbq_pkg::BYTES_W-1:0]   queued_bytes_now
);

  `PDBQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `PDBQ_ASSERT_NXT_ALWAYS(a_reset_clear, clk, !rst_n, !out_valid, "result valid after reset")
  `PDBQ_ASSERT_IMP(a_publish_fields, clk, rst_n, out_valid && out_ready && accepted, sent_bytes == '0 && !packet_done && queued_bytes_now != '0, "accepted publish with flush fields")
  `PDBQ_ASSERT_IMP(a_pop_fields, clk, rst_n, out_valid && out_ready && packet_done, sent_bytes != '0 && evicted_count == '0 && !accepted, "popped head with bad fields")

endmodule

bind priority_drop_byte_budget_queue pdbq_checker u_pdbq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .accepted        (out_chan.accepted),
  .evicted_count   (out_chan.evicted_count),
  .sent_bytes      (out_chan.sent_bytes),
  .packet_done     (out_chan.packet_done),
  .queued_bytes_now(out_chan.queued_bytes_now)
);

`default_nettype wire
